// ----- rtl/rrhl_pkg.sv -----
// Shared constants, types and helpers of the round-robin handoff lock.
package rrhl_pkg;

  // Number of requester slots that the waiting marks cover.
  localparam int MAX_SLOTS = 16;

  // Fixed field widths.
  localparam int FIELD_W = 4;  // requester and handoff slot fields
  localparam int TC_W    = 5;  // thread count register
  localparam logic [TC_W-1:0] TC_RESET = TC_W'(16);

  // Derived widths.
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OWN_W  = (SLOT_W > FIELD_W) ? SLOT_W : FIELD_W;
  localparam int CNT_A  = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W  = (CNT_A > OWN_W + 1) ? CNT_A : OWN_W + 1;

  // Operation codes of the func field.
  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OWN_W-1:0] own_t;

  // Commands from the sequencer to the scan unit.
  typedef struct packed {
    logic load;
    logic reduce;
    logic advance;
  } scan_cmd_t;

  // Status from the scan unit to the sequencer.
  typedef struct packed {
    cnt_t ptr;
    logic above_n;
    logic finished;
  } scan_stat_t;

  // Slots in use: the register clamped to the range one to MAX_SLOTS.
  function automatic cnt_t clamp_count(logic [TC_W-1:0] tc);
    cnt_t res;
    if (int'(tc) > MAX_SLOTS) begin
      res = CNT_W'(MAX_SLOTS);
    end else if (tc == '0) begin
      res = CNT_W'(1);
    end else begin
      res = CNT_W'(tc);
    end
    return res;
  endfunction

endpackage

// ----- rtl/rrhl_scan_unit.sv -----
// Shared pointer unit: modulo reduction and round-robin advance of the scan pointer.
module rrhl_scan_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  rrhl_pkg::scan_cmd_t cmd,
  input  rrhl_pkg::cnt_t      load_ptr,
  input  rrhl_pkg::cnt_t      load_cnt,
  input  rrhl_pkg::cnt_t      target,
  output rrhl_pkg::scan_stat_t stat
);
  import rrhl_pkg::*;

  cnt_t ptr_r, ptr_nxt;
  cnt_t n_r, n_nxt;
  cnt_t steps_r, steps_nxt;
  cnt_t diff;
  cnt_t inc;
  logic above;

  // One subtractor, one incrementer and one compare against the slot count.
  assign diff  = ptr_r - n_r;
  assign inc   = ptr_r + CNT_W'(1);
  assign above = (ptr_r >= n_r);

  always_comb begin
    ptr_nxt   = ptr_r;
    n_nxt     = n_r;
    steps_nxt = steps_r;
    if (cmd.load) begin
      ptr_nxt   = load_ptr;
      n_nxt     = load_cnt;
      steps_nxt = '0;
    end else if (cmd.reduce && above) begin
      ptr_nxt = diff;
    end else if (cmd.advance) begin
      ptr_nxt   = (inc == n_r) ? '0 : inc;
      steps_nxt = steps_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    n_r     <= n_nxt;
    steps_r <= steps_nxt;
  end

  assign stat.ptr      = ptr_r;
  assign stat.above_n  = above;
  assign stat.finished = (steps_r >= n_r) || (ptr_r == target);

  // The pointer is only advanced once it lies inside the slots in use.
  a_adv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (ptr_r < n_r))
    else $error("scan pointer advanced outside the slots in use");

endmodule

// ----- rtl/round_robin_handoff_lock.sv -----
// Top level of the round-robin handoff lock: sequencer, lock state and result register.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall  in_func, in_requester
//   out_      output     out_valid/out_stall out_granted_now, out_handoff,
//                                           out_handoff_slot, out_lock_busy
//   cfg_      input      cfg_valid/cfg_ready cfg_thread_count
//
// A lock request is settled in the cycle it is accepted. Its result passes through
// the result registers into the output register; the next request can be taken once
// it has been written there. An unlock first has the shared scan unit reduce the
// start slot modulo the slots in use by repeated subtraction, then visit one waiting
// mark per cycle.
// One request is worked on at a time; in_stall is high from acceptance until the
// result has been written to the output register, so a held result stretches it.
// Reset is synchronous, clears the lock and all waiting marks and sets the thread
// count to 16; the block is ready as soon as reset is released.
module round_robin_handoff_lock (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [rrhl_pkg::FIELD_W-1:0] in_requester,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_granted_now,
  output logic                        out_handoff,
  output logic [rrhl_pkg::FIELD_W-1:0] out_handoff_slot,
  output logic                        out_lock_busy,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rrhl_pkg::TC_W-1:0]   cfg_thread_count
);
  import rrhl_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [TC_W-1:0]      thread_count_r, thread_count_nxt;
  logic                 owner_valid_r, owner_valid_nxt;
  own_t                 owner_slot_r, owner_slot_nxt;
  logic [MAX_SLOTS-1:0] marks_r, marks_nxt;
  cnt_t                 req_r, req_nxt;

  // Result of the request in flight, waiting for the output register.
  logic                 res_granted_r, res_granted_nxt;
  logic                 res_handoff_r, res_handoff_nxt;
  logic [FIELD_W-1:0]   res_slot_r, res_slot_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic                 out_handoff_r, out_handoff_nxt;
  logic [FIELD_W-1:0]   out_slot_r, out_slot_nxt;
  logic                 out_busy_r, out_busy_nxt;

  logic                 in_acc;
  logic                 out_free;
  cnt_t                 in_req_ext;
  logic                 in_req_ok;
  scan_cmd_t            cmd;
  scan_stat_t           stat;
  cnt_t                 start_ptr;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Requesters beyond the marked slots neither set nor clear a mark.
  assign in_req_ext = CNT_W'(in_requester);
  assign in_req_ok  = (in_req_ext < CNT_W'(MAX_SLOTS));

  // The scan starts after the current owner, or at slot 0 when the lock is free.
  assign start_ptr = owner_valid_r ? (CNT_W'(owner_slot_r) + CNT_W'(1)) : '0;

  rrhl_scan_unit u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .load_ptr (start_ptr),
    .load_cnt (clamp_count(thread_count_r)),
    .target   (req_r),
    .stat     (stat)
  );

  always_comb begin
    state_nxt        = state_r;
    thread_count_nxt = thread_count_r;
    owner_valid_nxt  = owner_valid_r;
    owner_slot_nxt   = owner_slot_r;
    marks_nxt        = marks_r;
    req_nxt          = req_r;
    res_granted_nxt  = res_granted_r;
    res_handoff_nxt  = res_handoff_r;
    res_slot_nxt     = res_slot_r;
    cmd              = '0;

    if (cfg_valid && cfg_ready) begin
      thread_count_nxt = cfg_thread_count;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = in_req_ext;
          if (in_func == FUNC_LOCK) begin
            // A lock request is settled at once: take the free lock or wait.
            res_handoff_nxt = 1'b0;
            res_slot_nxt    = '0;
            if (!owner_valid_r) begin
              owner_valid_nxt = 1'b1;
              owner_slot_nxt  = OWN_W'(in_requester);
              res_granted_nxt = 1'b1;
            end else begin
              res_granted_nxt = 1'b0;
              if (in_req_ok) begin
                marks_nxt[in_req_ext[SLOT_W-1:0]] = 1'b1;
              end
            end
            state_nxt = ST_PUSH;
          end else begin
            // An unlock drops the releaser's own mark before the scan begins.
            if (in_req_ok) begin
              marks_nxt[in_req_ext[SLOT_W-1:0]] = 1'b0;
            end
            cmd.load  = 1'b1;
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // Bring the start slot into the range of slots in use.
        if (stat.above_n) begin
          cmd.reduce = 1'b1;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_granted_nxt = 1'b0;
        priority if (stat.finished) begin
          // Back at the releaser or every slot visited: the lock becomes free.
          owner_valid_nxt = 1'b0;
          owner_slot_nxt  = '0;
          res_handoff_nxt = 1'b0;
          res_slot_nxt    = '0;
          state_nxt       = ST_PUSH;
        end else if (marks_r[stat.ptr[SLOT_W-1:0]]) begin
          // First waiter found takes the lock and keeps its mark.
          owner_valid_nxt = 1'b1;
          owner_slot_nxt  = OWN_W'(stat.ptr);
          res_handoff_nxt = 1'b1;
          res_slot_nxt    = stat.ptr[FIELD_W-1:0];
          state_nxt       = ST_PUSH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished request once the slot is free.
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_handoff_nxt = out_handoff_r;
    out_slot_nxt    = out_slot_r;
    out_busy_nxt    = out_busy_r;
    if ((state_r == ST_PUSH) && out_free) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = res_granted_r;
      out_handoff_nxt = res_handoff_r;
      out_slot_nxt    = res_slot_r;
      out_busy_nxt    = owner_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      thread_count_r <= TC_RESET;
      owner_valid_r  <= 1'b0;
      owner_slot_r   <= '0;
      marks_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      thread_count_r <= thread_count_nxt;
      owner_valid_r  <= owner_valid_nxt;
      owner_slot_r   <= owner_slot_nxt;
      marks_r        <= marks_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    res_granted_r <= res_granted_nxt;
    res_handoff_r <= res_handoff_nxt;
    res_slot_r    <= res_slot_nxt;
    out_granted_r <= out_granted_nxt;
    out_handoff_r <= out_handoff_nxt;
    out_slot_r    <= out_slot_nxt;
    out_busy_r    <= out_busy_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_now  = out_granted_r;
  assign out_handoff      = out_handoff_r;
  assign out_handoff_slot = out_slot_r;
  assign out_lock_busy    = out_busy_r;

  // A free lock always records slot 0 as its owner.
  a_free_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (owner_slot_r == '0))
    else $error("lock free but owner slot not cleared");

  // A lock request that finds the lock free leaves it held.
  a_grant_takes_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FUNC_LOCK) && !owner_valid_r) |=> owner_valid_r)
    else $error("free lock not taken by a lock request");

  // A result never reports both an immediate grant and a handoff.
  a_grant_or_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_granted_r && out_handoff_r))
    else $error("result reports both grant and handoff");

  // A handoff result always reports a held lock.
  a_handoff_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_handoff_r) |-> out_busy_r)
    else $error("handoff reported with the lock free");

endmodule

// ----- tb/sv/round_robin_handoff_lock_tb.sv -----
// Self-checking testbench for the round-robin handoff lock, with its lock-state tracker.

// One result of the lock, in the order of the result ports.
typedef struct packed {
  logic                         granted_now;
  logic                         handoff;
  logic [rrhl_pkg::FIELD_W-1:0] handoff_slot;
  logic                         lock_busy;
} lock_outcome_t;

// Mirrors the lock state and holds the outcomes still owed by the block.
class lock_tracker;
  logic [rrhl_pkg::TC_W-1:0] thread_count;
  bit                        held;
  int unsigned               owner;
  bit                        waiting [rrhl_pkg::MAX_SLOTS];
  lock_outcome_t             owed_outcomes [$];
  int unsigned               mismatches, requests, grants, handoffs, cfg_writes;

  function new();
    thread_count = rrhl_pkg::TC_RESET;
    held = 1'b0;
    owner = 0;
    foreach (waiting[i]) waiting[i] = 1'b0;
  endfunction

  function void set_thread_count(logic [rrhl_pkg::TC_W-1:0] value);
    thread_count = value;
    cfg_writes++;
  endfunction

  function int unsigned slots_in_use();
    if (thread_count == 0) return 1;
    if (thread_count > rrhl_pkg::MAX_SLOTS) return rrhl_pkg::MAX_SLOTS;
    return thread_count;
  endfunction

  // Works out the outcome of one accepted request and updates the lock state.
  function void note_request(logic func, logic [rrhl_pkg::FIELD_W-1:0] requester);
    lock_outcome_t want;
    int unsigned   n, slot, steps;
    bit            found;
    want = '0;
    requests++;
    if (func == rrhl_pkg::FUNC_LOCK) begin
      if (!held) begin
        held = 1'b1;
        owner = requester;
        want.granted_now = 1'b1;
        grants++;
      end else begin
        waiting[requester] = 1'b1;
      end
    end else begin
      n = slots_in_use();
      slot = held ? (owner + 1) % n : 0;
      waiting[requester] = 1'b0;
      found = 1'b0;
      for (steps = 0; steps < n && slot != requester && !found; steps++) begin
        if (waiting[slot]) found = 1'b1;
        else slot = (slot + 1) % n;
      end
      if (found) begin
        held = 1'b1;
        owner = slot;
        want.handoff = 1'b1;
        want.handoff_slot = slot[rrhl_pkg::FIELD_W-1:0];
        handoffs++;
      end else begin
        held = 1'b0;
        owner = 0;
      end
    end
    want.lock_busy = held;
    owed_outcomes.push_back(want);
  endfunction

  function void check_result(lock_outcome_t got);
    lock_outcome_t want;
    if (owed_outcomes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: result %0d/%0d/%0d/%0d arrived with no request outstanding",
                 got.granted_now, got.handoff, got.handoff_slot, got.lock_busy);
      return;
    end
    want = owed_outcomes.pop_front();
    if (got.granted_now !== want.granted_now || got.handoff !== want.handoff ||
        got.handoff_slot !== want.handoff_slot || got.lock_busy !== want.lock_busy) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected granted_now=%0d handoff=%0d handoff_slot=%0d ",
                  "lock_busy=%0d, got %0d %0d %0d %0d"},
                 want.granted_now, want.handoff, want.handoff_slot, want.lock_busy,
                 got.granted_now, got.handoff, got.handoff_slot, got.lock_busy);
    end
  endfunction
endclass

module round_robin_handoff_lock_tb;
  import rrhl_pkg::*;

  // Cycles without any accepted request, result or register write before giving up.
  // The slowest correct stretch is a long output hold plus a full unlock scan.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = FUNC_LOCK;
  logic [FIELD_W-1:0] in_requester = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_granted_now;
  logic               out_handoff;
  logic [FIELD_W-1:0] out_handoff_slot;
  logic               out_lock_busy;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TC_W-1:0]    cfg_thread_count = '0;

  lock_tracker tracker = new();

  // Set by the sender to ask the receiver for one long hold-off; the receiver
  // counts the stretch itself and clears the flag.
  bit          hold_off_request = 1'b0;
  // When set, neither side idles any more: the closing part of the run.
  bit          steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned silent_cycles = 0;

  round_robin_handoff_lock dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_requester     (in_requester),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_now  (out_granted_now),
    .out_handoff      (out_handoff),
    .out_handoff_slot (out_handoff_slot),
    .out_lock_busy    (out_lock_busy),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_thread_count (cfg_thread_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver. Every result taken at an edge is checked against the oldest owed
  // outcome; then the stall for the next cycle is chosen. Stalls come in random
  // bursts, or as one long hold-off when the sender asks for it, so that the block
  // holds a finished result and has to stall its own input.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({out_granted_now, out_handoff, out_handoff_slot, out_lock_busy});
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !steady && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      silent_cycles <= 0;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
    if (silent_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Offers one request and waits for the block to take it. The valid stays high
  // on return; the caller either offers the next request at once or lowers it.
  task automatic send_request(input logic func, input logic [FIELD_W-1:0] requester);
    in_valid <= 1'b1;
    in_func <= func;
    in_requester <= requester;
    do @(posedge clk); while (in_stall);
    tracker.note_request(func, requester);
  endtask

  // A request followed, now and then, by a burst of idle cycles on the input side.
  task automatic issue(input logic func, input logic [FIELD_W-1:0] requester);
    send_request(func, requester);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed outcome has come back. Always lets
  // at least one edge pass, so the valid is never lowered and raised in one step.
  task automatic drain_outcomes();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed_outcomes.size() != 0);
  endtask

  // Every request produces exactly one result, so the block is idle once the
  // outcomes are drained and the register can be written safely.
  task automatic write_thread_count(input logic [TC_W-1:0] value);
    drain_outcomes();
    cfg_valid <= 1'b1;
    cfg_thread_count <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_thread_count(value);
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked sequences: unlock while free, the owner requesting again, unlock
  // by a non-owner, wrap-around of the scan, an owner and a releaser outside the
  // slots in use, and the register at zero and at its maximum.
  task automatic run_directed();
    issue(FUNC_UNLOCK, 4'd3);   // free lock: the scan starts at slot zero
    issue(FUNC_LOCK, 4'd0);     // immediate grant
    issue(FUNC_LOCK, 4'd0);     // the owner itself is marked as waiting
    issue(FUNC_LOCK, 4'd5);
    issue(FUNC_LOCK, 4'd15);
    issue(FUNC_UNLOCK, 4'd0);   // handoff to slot five, which keeps its mark
    issue(FUNC_UNLOCK, 4'd9);   // a non-owner releases; the scan stops at slot nine
    issue(FUNC_LOCK, 4'd10);
    issue(FUNC_UNLOCK, 4'd10);  // handoff to the highest slot
    issue(FUNC_UNLOCK, 4'd15);  // the scan wraps and finds slot five
    issue(FUNC_UNLOCK, 4'd5);
    write_thread_count(5'd4);
    issue(FUNC_LOCK, 4'd12);    // owner outside the slots in use
    issue(FUNC_LOCK, 4'd2);
    issue(FUNC_LOCK, 4'd14);
    issue(FUNC_UNLOCK, 4'd9);   // releaser outside the scanned range
    issue(FUNC_UNLOCK, 4'd2);
    issue(FUNC_UNLOCK, 4'd7);   // free lock, each slot in use visited once
    write_thread_count(5'd0);   // behaves as a single slot
    issue(FUNC_LOCK, 4'd3);
    issue(FUNC_LOCK, 4'd0);
    issue(FUNC_UNLOCK, 4'd3);
    issue(FUNC_UNLOCK, 4'd0);
    write_thread_count(5'd31);  // clamped to the full set of slots
    issue(FUNC_LOCK, 4'd15);
    issue(FUNC_LOCK, 4'd14);
    issue(FUNC_UNLOCK, 4'd15);
    issue(FUNC_UNLOCK, 4'd14);
  endtask

  // Random traffic shaped like real use: mostly slots in use, locks more likely
  // while the lock is free, and most unlocks while it is held coming from the
  // current owner. The rest is noise from any slot.
  task automatic run_random_phase(input int unsigned count);
    int unsigned        n, i;
    logic               func;
    logic [FIELD_W-1:0] requester;
    n = tracker.slots_in_use();
    for (i = 0; i < count; i++) begin
      if (!tracker.held)
        func = ($urandom_range(0, 9) < 7) ? FUNC_LOCK : FUNC_UNLOCK;
      else
        func = ($urandom_range(0, 9) < 5) ? FUNC_LOCK : FUNC_UNLOCK;
      if (func == FUNC_UNLOCK && tracker.held && $urandom_range(0, 9) < 6)
        requester = tracker.owner[FIELD_W-1:0];
      else if ($urandom_range(0, 4) != 0)
        requester = FIELD_W'($urandom_range(0, n - 1));
      else
        requester = FIELD_W'($urandom_range(0, MAX_SLOTS - 1));
      issue(func, requester);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Full set of slots, opened with one long hold-off on the result side while
    // requests keep coming, so the block backs up to its input.
    write_thread_count(5'd16);
    hold_off_request = 1'b1;
    run_random_phase(50);

    write_thread_count(5'd1);
    run_random_phase(50);

    // Midway the sender waits for every outcome before carrying on.
    write_thread_count(5'd3);
    run_random_phase(25);
    drain_outcomes();
    run_random_phase(25);

    write_thread_count(5'd31);
    run_random_phase(50);

    write_thread_count(5'd0);
    run_random_phase(50);

    write_thread_count(TC_W'($urandom_range(2, 15)));
    run_random_phase(50);

    write_thread_count(5'd8);
    run_random_phase(50);

    // Closing part at full rate on both sides.
    write_thread_count(5'd16);
    steady = 1'b1;
    run_random_phase(50);

    drain_outcomes();
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests: %0d immediate grants, %0d handoffs, %0d register writes.",
             tracker.requests, tracker.grants, tracker.handoffs, tracker.cfg_writes);
    $display("Slot counts from zero to thirty-one were used; %0d mismatches, %0d outcomes owed.",
             tracker.mismatches, tracker.owed_outcomes.size());
    if (tracker.mismatches == 0 && tracker.owed_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rrhl_pkg.sv
rtl/rrhl_scan_unit.sv
rtl/round_robin_handoff_lock.sv
tb/sv/round_robin_handoff_lock_tb.sv
